FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types and constants of the single-precision multiplier.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam logic [9:0]  ExpOffset = 10'd129;
  localparam logic [22:0] FracOnes  = 23'h7FFFFF;
  localparam logic [7:0]  ExpMax    = 8'hFF;

  typedef struct packed {
    logic        sign;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
  } unpacked_t;

endpackage

FILE: hw/rtl/single_float_multiplier.sv
// ----------------------------------------------------------------------------
// single_float_multiplier
// Truncated single-precision multiplier, one item per cycle.
// ----------------------------------------------------------------------------
// Takes an item every cycle (busy_o is always low). The operands are
// registered in op_q on start_i, the product is formed by combinational logic
// and registered in prod_q; done_o strobes from done_q, behind vld_q, for one
// cycle. The receiver cannot stall, so no result is ever held back.
`include "assert_macros.svh"

module single_float_multiplier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] product_o
);

  sfm_pkg::unpacked_t op_d, op_q;
  logic               vld_q, done_q;
  logic [31:0]        prod_d, prod_q;

  assign busy_o = 1'b0;

  always_comb begin
    op_d.sign = operand_a_i[31] ^ operand_b_i[31];
    op_d.ea   = operand_a_i[30:23];
    op_d.eb   = operand_b_i[30:23];
    op_d.ma   = {1'b1, operand_a_i[22:0]};
    op_d.mb   = {1'b1, operand_b_i[22:0]};
  end

  sfm_core u_core (
    .op_i      (op_q),
    .product_o (prod_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start_i;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) op_q <= op_d;
    if (vld_q) prod_q <= prod_d;
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

  `ASSERT_NEXT(a_done_follows, clk_i, rst_ni, vld_q, done_o)
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !vld_q, !done_o)
  `ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)

endmodule

FILE: hw/rtl/sfm_core.sv
// ----------------------------------------------------------------------------
// sfm_core
// Combinational significand product, normalize, round and pack.
// ----------------------------------------------------------------------------
module sfm_core (
  input  sfm_pkg::unpacked_t op_i,
  output logic [31:0]        product_o
);

  logic [12:0] ah, bh;
  logic [10:0] al, bl;
  logic [25:0] hh;
  logic [23:0] hl, lh;
  logic [3:0]  ll;
  logic [27:0] m;
  logic [9:0]  ex;
  logic [7:0]  ex8;
  logic [22:0] hi_frac, lo_frac;
  logic [7:0]  e_out;
  logic [22:0] f_out;

  always_comb begin
    ah = op_i.ma[23:11];
    al = op_i.ma[10:0];
    bh = op_i.mb[23:11];
    bl = op_i.mb[10:0];
    hh = ah * bh;
    hl = ah * bl;
    lh = al * bh;
    ll = al[10:9] * bl[10:9];
    m  = {hh, 2'b00} + {13'd0, hl[23:9]} + {13'd0, lh[23:9]} + {26'd0, ll[3:2]};
    ex  = {2'b00, op_i.ea} + {2'b00, op_i.eb} + sfm_pkg::ExpOffset;
    ex8 = ex[7:0];
    hi_frac = m[26:4];
    lo_frac = m[25:3];
    if (op_i.ea == 8'd0 || op_i.eb == 8'd0 || ex[9:8] == 2'b00) begin
      e_out = 8'd0;
      f_out = 23'd0;
    end else if (ex[9]) begin
      e_out = sfm_pkg::ExpMax;
      f_out = 23'd0;
    end else if (m[27] && ex8 != sfm_pkg::ExpMax) begin
      if (m[3]) begin
        e_out = ex8 + 8'd1 + {7'd0, hi_frac == sfm_pkg::FracOnes};
        f_out = hi_frac + 23'd1;
      end else begin
        e_out = ex8 + 8'd1;
        f_out = hi_frac;
      end
    end else begin
      if (m[2]) begin
        e_out = ex8 + {7'd0, lo_frac == sfm_pkg::FracOnes};
        f_out = lo_frac + 23'd1;
      end else begin
        e_out = ex8;
        f_out = lo_frac;
      end
    end
    product_o = {op_i.sign, e_out, f_out};
  end

endmodule

FILE: test/tb_single_float_multiplier.sv
// ----------------------------------------------------------------------------
// tb_single_float_multiplier
// Self-checking testbench of the truncated single-precision multiplier.
// ----------------------------------------------------------------------------
// Drives operand pairs through the start/busy handshake and predicts each
// product with a bit-exact model of the truncated datapath. Products that
// strobe on done_o are compared in order against the queue of expected words.
// Directed corner operands come first, then random items in three idle phases.
`timescale 1ns / 100ps

class product_board;
  logic [31:0] pending[$];
  int errors = 0;

  function logic [31:0] multiply(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [7:0]  ea, eb, ex8;
    logic [9:0]  ex;
    logic [23:0] ma, mb;
    logic [12:0] ah, bh;
    logic [10:0] al, bl;
    logic [31:0] hh, hl, lh, ll, m;
    logic [22:0] hf, lf;
    logic [31:0] r;
    sgn = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    ma = {1'b1, a[22:0]};
    mb = {1'b1, b[22:0]};
    ex = 10'(ea) + 10'(eb) + sfm_pkg::ExpOffset;
    ex8 = ex[7:0];
    ah = ma[23:11]; al = ma[10:0];
    bh = mb[23:11]; bl = mb[10:0];
    hh = 32'(ah) * 32'(bh);
    hl = 32'(ah) * 32'(bl);
    lh = 32'(al) * 32'(bh);
    ll = 32'(al[10:9]) * 32'(bl[10:9]);
    m = (hh << 2) + ((hl >> 9) & 32'h7FFF) + ((lh >> 9) & 32'h7FFF) + ((ll >> 2) & 32'd3);
    hf = m[26:4];
    lf = m[25:3];
    if (ea == 0 || eb == 0 || ex[9:8] == 2'b00) r = {sgn, 31'd0};
    else if (ex[9]) r = {sgn, sfm_pkg::ExpMax, 23'd0};
    else if (m[27] && ex8 != sfm_pkg::ExpMax) begin
      if (m[3:0] >= 4'd8)
        r = {sgn, 8'(ex8 + 8'd1 + 8'(hf == sfm_pkg::FracOnes)), 23'(hf + 23'd1)};
      else r = {sgn, 8'(ex8 + 8'd1), hf};
    end else begin
      if (m[2:0] >= 3'd4)
        r = {sgn, 8'(ex8 + 8'(lf == sfm_pkg::FracOnes)), 23'(lf + 23'd1)};
      else r = {sgn, ex8, lf};
    end
    return r;
  endfunction

  function void note_item(logic [31:0] a, logic [31:0] b);
    pending.push_back(multiply(a, b));
  endfunction

  function void check_product(logic [31:0] got);
    logic [31:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected product %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: product mismatch expected %h actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_single_float_multiplier;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        done_o;
  logic [31:0] product_o;

  product_board board = new();
  int idle_pct = 0;
  int stalled = 0;
  bit timed_out = 1'b0;

  single_float_multiplier uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_product(product_o);
    if (rst_ni && ((start_i && !busy_o) || done_o)) stalled <= 0;
    else stalled <= stalled + 1;
    if (stalled > 2000) begin
      timed_out = 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'($urandom_range(0, 20));
      3: v[30:23] = 8'($urandom_range(235, 255));
      4: v[22:0] = sfm_pkg::FracOnes;
      5: v[22:0] = 23'd0;
      default: v[30:23] = 8'($urandom_range(64, 190));
    endcase
    return v;
  endfunction

  task automatic send_item(logic [31:0] a, logic [31:0] b);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    board.note_item(a, b);
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(rand_operand(), rand_operand());
  endtask

  logic [31:0] corners[12] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3F80_0000,
                               32'hBF80_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFFFF_FFFF,
                               32'h3FFF_FFFF, 32'h0080_0000, 32'h3FB5_04F3, 32'h4000_0000};

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (corners[i]) send_item(corners[i], corners[(i * 5 + 3) % 12]);
    send_item(32'h3FFF_FFFF, 32'h3FFF_FFFF);
    send_item(32'h2000_0000, 32'h1F00_0000);
    send_item(32'h7F00_0000, 32'h7F00_0000);
    send_item(32'h4300_0000, 32'h3C00_0000);
    send_item(32'h7F80_0000, 32'h3F80_0000);
    idle_pct = 37;
    run_random(620);
    idle_pct = 65;
    run_random(620);
    idle_pct = 0;
    run_random(610);
    start_i <= 1'b0;
    while (board.pending.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (timed_out) $display("[FAIL] regression broken");
    else if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
